// ===== src/cta_pkg.sv =====
// Shared constants for the calendar time offset adder.
package cta_pkg;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int MILLIS_W = 16;
    localparam int ADD_DAY_W    = 6;
    localparam int ADD_HOUR_W   = 7;
    localparam int ADD_MINUTE_W = 8;
    localparam int ADD_MILLIS_W = 18;
    localparam int OUT_DAY_W    = 7;

    // Month codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Divisibility by 25 of a 14-bit year: multiply by the modular inverse
    // of 25 and compare against (2^14 - 1) / 25.
    localparam logic [YEAR_W-1:0] INV25_MOD_YEAR = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT    = 14'd655;

endpackage

// ===== src/calendar_time_offset_adder.sv =====
// Calendar time plus signed offset: carries, leap rule and one-month day fix.
// Pipeline: a beat accepted is held in the input register, then moves into
// the result register once that register is empty or its result is taken.
// Throughput: one beat per cycle while results are taken; the input register
// holds one more beat while a result waits for out_ready.
// Reset: rst_n clears both valid flags; payload registers are not reset.
module calendar_time_offset_adder (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic        [cta_pkg::YEAR_W-1:0]        base_year,
    input  logic        [cta_pkg::MONTH_W-1:0]       base_month,
    input  logic        [cta_pkg::DAY_W-1:0]         base_day,
    input  logic        [cta_pkg::HOUR_W-1:0]        base_hour,
    input  logic        [cta_pkg::MINUTE_W-1:0]      base_minute,
    input  logic        [cta_pkg::MILLIS_W-1:0]      base_millis,
    input  logic signed [cta_pkg::ADD_DAY_W-1:0]     add_day,
    input  logic signed [cta_pkg::ADD_HOUR_W-1:0]    add_hour,
    input  logic signed [cta_pkg::ADD_MINUTE_W-1:0]  add_minute,
    input  logic signed [cta_pkg::ADD_MILLIS_W-1:0]  add_millis,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic        [cta_pkg::YEAR_W-1:0]        out_year,
    output logic        [cta_pkg::MONTH_W-1:0]       out_month,
    output logic signed [cta_pkg::OUT_DAY_W-1:0]     out_day,
    output logic        [cta_pkg::HOUR_W-1:0]        out_hour,
    output logic        [cta_pkg::MINUTE_W-1:0]      out_minute,
    output logic        [cta_pkg::MILLIS_W-1:0]      out_millis
);

    // Input register
    logic                                     s1_valid_reg;
    logic        [cta_pkg::YEAR_W-1:0]        year_reg;
    logic        [cta_pkg::MONTH_W-1:0]       month_reg;
    logic        [cta_pkg::DAY_W-1:0]         day_reg;
    logic        [cta_pkg::HOUR_W-1:0]        hour_reg;
    logic        [cta_pkg::MINUTE_W-1:0]      minute_reg;
    logic        [cta_pkg::MILLIS_W-1:0]      millis_reg;
    logic signed [cta_pkg::ADD_DAY_W-1:0]     add_day_reg;
    logic signed [cta_pkg::ADD_HOUR_W-1:0]    add_hour_reg;
    logic signed [cta_pkg::ADD_MINUTE_W-1:0]  add_minute_reg;
    logic signed [cta_pkg::ADD_MILLIS_W-1:0]  add_millis_reg;

    // Result register
    logic                                     out_valid_reg;
    logic        [cta_pkg::YEAR_W-1:0]        out_year_reg;
    logic        [cta_pkg::MONTH_W-1:0]       out_month_reg;
    logic signed [cta_pkg::OUT_DAY_W-1:0]     out_day_reg;
    logic        [cta_pkg::HOUR_W-1:0]        out_hour_reg;
    logic        [cta_pkg::MINUTE_W-1:0]      out_minute_reg;
    logic        [cta_pkg::MILLIS_W-1:0]      out_millis_reg;

    // Next result values
    logic        [cta_pkg::YEAR_W-1:0]        out_year_next;
    logic        [cta_pkg::MONTH_W-1:0]       out_month_next;
    logic signed [cta_pkg::OUT_DAY_W-1:0]     out_day_next;
    logic        [cta_pkg::HOUR_W-1:0]        out_hour_next;
    logic        [cta_pkg::MINUTE_W-1:0]      out_minute_next;
    logic        [cta_pkg::MILLIS_W-1:0]      out_millis_next;

    // Arithmetic intermediates
    logic signed [18:0] ms_sum;
    logic signed [18:0] ms_rem;
    logic signed [2:0]  ms_carry;
    logic signed [8:0]  min_sum;
    logic signed [8:0]  min_rem;
    logic signed [2:0]  min_carry;
    logic signed [7:0]  hr_sum;
    logic signed [7:0]  hr_rem;
    logic signed [3:0]  hr_carry;
    logic signed [7:0]  day_sum;
    logic signed [7:0]  day_fix;
    logic signed [7:0]  feb_len;
    logic [cta_pkg::YEAR_W-1:0] year_inv25;
    logic div25;
    logic leap;

    logic advance_out;

    // Handshake: the result register frees when empty or taken
    assign advance_out = !out_valid_reg || out_ready;
    assign in_ready    = !s1_valid_reg || advance_out;
    assign out_valid   = out_valid_reg;

    // Carry milliseconds into minutes by floor division
    always_comb
    begin
        ms_sum = $signed({3'b000, millis_reg}) + 19'(add_millis_reg);
        if (ms_sum >= 19'sd180000)
        begin
            ms_carry = 3'sd3;
            ms_rem   = ms_sum - 19'sd180000;
        end
        else if (ms_sum >= 19'sd120000)
        begin
            ms_carry = 3'sd2;
            ms_rem   = ms_sum - 19'sd120000;
        end
        else if (ms_sum >= 19'sd60000)
        begin
            ms_carry = 3'sd1;
            ms_rem   = ms_sum - 19'sd60000;
        end
        else if (ms_sum >= 19'sd0)
        begin
            ms_carry = 3'sd0;
            ms_rem   = ms_sum;
        end
        else if (ms_sum >= -19'sd60000)
        begin
            ms_carry = -3'sd1;
            ms_rem   = ms_sum + 19'sd60000;
        end
        else if (ms_sum >= -19'sd120000)
        begin
            ms_carry = -3'sd2;
            ms_rem   = ms_sum + 19'sd120000;
        end
        else
        begin
            ms_carry = -3'sd3;
            ms_rem   = ms_sum + 19'sd180000;
        end
    end

    // Carry minutes into hours
    always_comb
    begin
        min_sum = $signed({3'b000, minute_reg}) + 9'(add_minute_reg) + 9'(ms_carry);
        if (min_sum >= 9'sd180)
        begin
            min_carry = 3'sd3;
            min_rem   = min_sum - 9'sd180;
        end
        else if (min_sum >= 9'sd120)
        begin
            min_carry = 3'sd2;
            min_rem   = min_sum - 9'sd120;
        end
        else if (min_sum >= 9'sd60)
        begin
            min_carry = 3'sd1;
            min_rem   = min_sum - 9'sd60;
        end
        else if (min_sum >= 9'sd0)
        begin
            min_carry = 3'sd0;
            min_rem   = min_sum;
        end
        else if (min_sum >= -9'sd60)
        begin
            min_carry = -3'sd1;
            min_rem   = min_sum + 9'sd60;
        end
        else if (min_sum >= -9'sd120)
        begin
            min_carry = -3'sd2;
            min_rem   = min_sum + 9'sd120;
        end
        else
        begin
            min_carry = -3'sd3;
            min_rem   = min_sum + 9'sd180;
        end
    end

    // Carry hours into days
    always_comb
    begin
        hr_sum = $signed({3'b000, hour_reg}) + 8'(add_hour_reg) + 8'(min_carry);
        if (hr_sum >= 8'sd96)
        begin
            hr_carry = 4'sd4;
            hr_rem   = hr_sum - 8'sd96;
        end
        else if (hr_sum >= 8'sd72)
        begin
            hr_carry = 4'sd3;
            hr_rem   = hr_sum - 8'sd72;
        end
        else if (hr_sum >= 8'sd48)
        begin
            hr_carry = 4'sd2;
            hr_rem   = hr_sum - 8'sd48;
        end
        else if (hr_sum >= 8'sd24)
        begin
            hr_carry = 4'sd1;
            hr_rem   = hr_sum - 8'sd24;
        end
        else if (hr_sum >= 8'sd0)
        begin
            hr_carry = 4'sd0;
            hr_rem   = hr_sum;
        end
        else if (hr_sum >= -8'sd24)
        begin
            hr_carry = -4'sd1;
            hr_rem   = hr_sum + 8'sd24;
        end
        else if (hr_sum >= -8'sd48)
        begin
            hr_carry = -4'sd2;
            hr_rem   = hr_sum + 8'sd48;
        end
        else
        begin
            hr_carry = -4'sd3;
            hr_rem   = hr_sum + 8'sd72;
        end
    end

    // Gregorian leap rule; divisible by 100 is by 4 and by 25
    assign year_inv25 = cta_pkg::YEAR_W'(year_reg * cta_pkg::INV25_MOD_YEAR);
    assign div25      = (year_inv25 <= cta_pkg::DIV25_LIMIT);
    assign leap       = ((year_reg[1:0] == 2'b00) && !div25)
                     || ((year_reg[3:0] == 4'b0000) && div25);
    assign feb_len    = leap ? 8'sd29 : 8'sd28;

    // Correct the day across one month boundary
    always_comb
    begin
        day_sum         = $signed({3'b000, day_reg}) + 8'(add_day_reg) + 8'(hr_carry);
        day_fix         = day_sum;
        out_month_next  = month_reg;
        out_year_next   = year_reg;
        if (day_sum < 8'sd1)
        begin
            case (month_reg) inside
                cta_pkg::MONTH_FEB, cta_pkg::MONTH_APR, cta_pkg::MONTH_JUN,
                cta_pkg::MONTH_AUG, cta_pkg::MONTH_SEP, cta_pkg::MONTH_NOV:
                begin
                    out_month_next = month_reg - 4'd1;
                    day_fix        = day_sum + 8'sd31;
                end
                cta_pkg::MONTH_MAY, cta_pkg::MONTH_JUL, cta_pkg::MONTH_OCT,
                cta_pkg::MONTH_DEC:
                begin
                    out_month_next = month_reg - 4'd1;
                    day_fix        = day_sum + 8'sd30;
                end
                cta_pkg::MONTH_JAN:
                begin
                    out_month_next = cta_pkg::MONTH_DEC;
                    day_fix        = day_sum + 8'sd31;
                    out_year_next  = year_reg - 14'd1;
                end
                cta_pkg::MONTH_MAR:
                begin
                    out_month_next = cta_pkg::MONTH_FEB;
                    day_fix        = day_sum + feb_len;
                end
                default:
                begin
                    out_month_next = month_reg;
                end
            endcase
        end
        else if (day_sum > feb_len)
        begin
            case (month_reg) inside
                cta_pkg::MONTH_JAN, cta_pkg::MONTH_MAR, cta_pkg::MONTH_MAY,
                cta_pkg::MONTH_JUL, cta_pkg::MONTH_AUG, cta_pkg::MONTH_OCT:
                begin
                    if (day_sum > 8'sd31)
                    begin
                        out_month_next = month_reg + 4'd1;
                        day_fix        = day_sum - 8'sd31;
                    end
                end
                cta_pkg::MONTH_APR, cta_pkg::MONTH_JUN, cta_pkg::MONTH_SEP,
                cta_pkg::MONTH_NOV:
                begin
                    if (day_sum > 8'sd30)
                    begin
                        out_month_next = month_reg + 4'd1;
                        day_fix        = day_sum - 8'sd30;
                    end
                end
                cta_pkg::MONTH_FEB:
                begin
                    out_month_next = cta_pkg::MONTH_MAR;
                    day_fix        = day_sum - feb_len;
                end
                cta_pkg::MONTH_DEC:
                begin
                    if (day_sum > 8'sd31)
                    begin
                        out_month_next = cta_pkg::MONTH_JAN;
                        day_fix        = day_sum - 8'sd31;
                        out_year_next  = year_reg + 14'd1;
                    end
                end
                default:
                begin
                    out_month_next = month_reg;
                end
            endcase
        end
    end

    assign out_day_next    = day_fix[cta_pkg::OUT_DAY_W-1:0];
    assign out_hour_next   = hr_rem[cta_pkg::HOUR_W-1:0];
    assign out_minute_next = min_rem[cta_pkg::MINUTE_W-1:0];
    assign out_millis_next = ms_rem[cta_pkg::MILLIS_W-1:0];

    // Hold and advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            year_reg       <= base_year;
            month_reg      <= base_month;
            day_reg        <= base_day;
            hour_reg       <= base_hour;
            minute_reg     <= base_minute;
            millis_reg     <= base_millis;
            add_day_reg    <= add_day;
            add_hour_reg   <= add_hour;
            add_minute_reg <= add_minute;
            add_millis_reg <= add_millis;
        end
    end

    // Load the result when the output stage frees
    always_ff @(posedge clk)
    begin
        if (advance_out && s1_valid_reg)
        begin
            out_year_reg   <= out_year_next;
            out_month_reg  <= out_month_next;
            out_day_reg    <= out_day_next;
            out_hour_reg   <= out_hour_next;
            out_minute_reg <= out_minute_next;
            out_millis_reg <= out_millis_next;
        end
    end

    assign out_year   = out_year_reg;
    assign out_month  = out_month_reg;
    assign out_day    = out_day_reg;
    assign out_hour   = out_hour_reg;
    assign out_minute = out_minute_reg;
    assign out_millis = out_millis_reg;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the calendar time offset adder.
module tb;

    // One input beat as driven onto the ports
    typedef struct {
        logic        [cta_pkg::YEAR_W-1:0]       base_year;
        logic        [cta_pkg::MONTH_W-1:0]      base_month;
        logic        [cta_pkg::DAY_W-1:0]        base_day;
        logic        [cta_pkg::HOUR_W-1:0]       base_hour;
        logic        [cta_pkg::MINUTE_W-1:0]     base_minute;
        logic        [cta_pkg::MILLIS_W-1:0]     base_millis;
        logic signed [cta_pkg::ADD_DAY_W-1:0]    add_day;
        logic signed [cta_pkg::ADD_HOUR_W-1:0]   add_hour;
        logic signed [cta_pkg::ADD_MINUTE_W-1:0] add_minute;
        logic signed [cta_pkg::ADD_MILLIS_W-1:0] add_millis;
    } cal_item_t;

    // One result beat
    typedef struct {
        logic        [cta_pkg::YEAR_W-1:0]    year;
        logic        [cta_pkg::MONTH_W-1:0]   month;
        logic signed [cta_pkg::OUT_DAY_W-1:0] day;
        logic        [cta_pkg::HOUR_W-1:0]    hour;
        logic        [cta_pkg::MINUTE_W-1:0]  minute;
        logic        [cta_pkg::MILLIS_W-1:0]  millis;
    } cal_result_t;

    // Predicts each sum and matches it against the result beats in order
    class cal_scoreboard_t;
        cal_result_t expected_times[$];
        int          mismatches = 0;

        static function longint floor_div(longint a, longint d);
            longint q;
            q = a / d;
            if ((a % d) < 0)
                q -= 1;
            return q;
        endfunction

        static function cal_result_t add_offset(cal_item_t it);
            cal_result_t r;
            longint yr, mon, dy, hr, mn, ms, c, leap;
            yr  = it.base_year;
            mon = it.base_month;
            dy  = it.base_day;
            hr  = it.base_hour;
            mn  = it.base_minute;
            ms  = it.base_millis;

            // Carry milliseconds into minutes, minutes into hours, hours into days
            ms += it.add_millis;
            c   = floor_div(ms, 60000);
            ms -= c * 60000;
            mn += it.add_minute;
            mn += c;
            c   = floor_div(mn, 60);
            mn -= c * 60;
            hr += it.add_hour;
            hr += c;
            c   = floor_div(hr, 24);
            hr -= c * 24;
            dy += it.add_day;
            dy += c;

            leap = (((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0) ? 1 : 0;

            // Fix the day across one month boundary at most
            if (dy < 1)
            begin
                case (mon)
                    cta_pkg::MONTH_FEB, cta_pkg::MONTH_APR, cta_pkg::MONTH_JUN,
                    cta_pkg::MONTH_AUG, cta_pkg::MONTH_SEP, cta_pkg::MONTH_NOV:
                    begin
                        mon -= 1;
                        dy  += 31;
                    end
                    cta_pkg::MONTH_MAY, cta_pkg::MONTH_JUL, cta_pkg::MONTH_OCT,
                    cta_pkg::MONTH_DEC:
                    begin
                        mon -= 1;
                        dy  += 30;
                    end
                    cta_pkg::MONTH_JAN:
                    begin
                        mon = cta_pkg::MONTH_DEC;
                        dy += 31;
                        yr -= 1;
                    end
                    cta_pkg::MONTH_MAR:
                    begin
                        mon = cta_pkg::MONTH_FEB;
                        dy += 28 + leap;
                    end
                    default: ;
                endcase
            end
            else if (dy > 28 + leap)
            begin
                case (mon)
                    cta_pkg::MONTH_JAN, cta_pkg::MONTH_MAR, cta_pkg::MONTH_MAY,
                    cta_pkg::MONTH_JUL, cta_pkg::MONTH_AUG, cta_pkg::MONTH_OCT:
                        if (dy > 31)
                        begin
                            mon += 1;
                            dy  -= 31;
                        end
                    cta_pkg::MONTH_APR, cta_pkg::MONTH_JUN, cta_pkg::MONTH_SEP,
                    cta_pkg::MONTH_NOV:
                        if (dy > 30)
                        begin
                            mon += 1;
                            dy  -= 30;
                        end
                    cta_pkg::MONTH_FEB:
                    begin
                        mon = cta_pkg::MONTH_MAR;
                        dy -= 28 + leap;
                    end
                    cta_pkg::MONTH_DEC:
                        if (dy > 31)
                        begin
                            mon = cta_pkg::MONTH_JAN;
                            dy -= 31;
                            yr += 1;
                        end
                    default: ;
                endcase
            end

            r.year   = cta_pkg::YEAR_W'(yr);
            r.month  = cta_pkg::MONTH_W'(mon);
            r.day    = cta_pkg::OUT_DAY_W'(dy);
            r.hour   = cta_pkg::HOUR_W'(hr);
            r.minute = cta_pkg::MINUTE_W'(mn);
            r.millis = cta_pkg::MILLIS_W'(ms);
            return r;
        endfunction

        function void note_item(cal_item_t it);
            expected_times.push_back(add_offset(it));
        endfunction

        function void compare_field(string name, longint exp_v, longint got_v);
            if (exp_v != got_v)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_result(cal_result_t got);
            cal_result_t exp_r;
            if (expected_times.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %0d-%0d-%0d",
                         $time, got.year, got.month, got.day);
                mismatches++;
                return;
            end
            exp_r = expected_times.pop_front();
            compare_field("year",   exp_r.year,   got.year);
            compare_field("month",  exp_r.month,  got.month);
            compare_field("day",    exp_r.day,    got.day);
            compare_field("hour",   exp_r.hour,   got.hour);
            compare_field("minute", exp_r.minute, got.minute);
            compare_field("millis", exp_r.millis, got.millis);
        endfunction
    endclass

    logic                                    clk;
    logic                                    rst_n;
    logic                                    in_valid;
    logic                                    in_ready;
    logic        [cta_pkg::YEAR_W-1:0]       base_year;
    logic        [cta_pkg::MONTH_W-1:0]      base_month;
    logic        [cta_pkg::DAY_W-1:0]        base_day;
    logic        [cta_pkg::HOUR_W-1:0]       base_hour;
    logic        [cta_pkg::MINUTE_W-1:0]     base_minute;
    logic        [cta_pkg::MILLIS_W-1:0]     base_millis;
    logic signed [cta_pkg::ADD_DAY_W-1:0]    add_day;
    logic signed [cta_pkg::ADD_HOUR_W-1:0]   add_hour;
    logic signed [cta_pkg::ADD_MINUTE_W-1:0] add_minute;
    logic signed [cta_pkg::ADD_MILLIS_W-1:0] add_millis;
    logic                                    out_valid;
    logic                                    out_ready;
    logic        [cta_pkg::YEAR_W-1:0]       out_year;
    logic        [cta_pkg::MONTH_W-1:0]      out_month;
    logic signed [cta_pkg::OUT_DAY_W-1:0]    out_day;
    logic        [cta_pkg::HOUR_W-1:0]       out_hour;
    logic        [cta_pkg::MINUTE_W-1:0]     out_minute;
    logic        [cta_pkg::MILLIS_W-1:0]     out_millis;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    cal_scoreboard_t sb = new();

    calendar_time_offset_adder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .base_year   (base_year),
        .base_month  (base_month),
        .base_day    (base_day),
        .base_hour   (base_hour),
        .base_minute (base_minute),
        .base_millis (base_millis),
        .add_day     (add_day),
        .add_hour    (add_hour),
        .add_minute  (add_minute),
        .add_millis  (add_millis),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_year    (out_year),
        .out_month   (out_month),
        .out_day     (out_day),
        .out_hour    (out_hour),
        .out_minute  (out_minute),
        .out_millis  (out_millis)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // Drive out_ready: a long hold-off when asked, else random stalls
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Note accepted input beats and check accepted result beats
    always @(posedge clk)
    begin
        cal_item_t   it;
        cal_result_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                it.base_year   = base_year;
                it.base_month  = base_month;
                it.base_day    = base_day;
                it.base_hour   = base_hour;
                it.base_minute = base_minute;
                it.base_millis = base_millis;
                it.add_day     = add_day;
                it.add_hour    = add_hour;
                it.add_minute  = add_minute;
                it.add_millis  = add_millis;
                sb.note_item(it);
            end
            if (out_valid && out_ready)
            begin
                got.year   = out_year;
                got.month  = out_month;
                got.day    = out_day;
                got.hour   = out_hour;
                got.minute = out_minute;
                got.millis = out_millis;
                sb.check_result(got);
            end
        end
    end

    function automatic cal_item_t mk(int y, int mo, int d, int h, int mi, int ms,
                                     int ad, int ah, int am, int ams);
        cal_item_t it;
        it.base_year   = cta_pkg::YEAR_W'(y);
        it.base_month  = cta_pkg::MONTH_W'(mo);
        it.base_day    = cta_pkg::DAY_W'(d);
        it.base_hour   = cta_pkg::HOUR_W'(h);
        it.base_minute = cta_pkg::MINUTE_W'(mi);
        it.base_millis = cta_pkg::MILLIS_W'(ms);
        it.add_day     = cta_pkg::ADD_DAY_W'(ad);
        it.add_hour    = cta_pkg::ADD_HOUR_W'(ah);
        it.add_minute  = cta_pkg::ADD_MINUTE_W'(am);
        it.add_millis  = cta_pkg::ADD_MILLIS_W'(ams);
        return it;
    endfunction

    function automatic int pick_year();
        case ($urandom_range(5))
            0: return 1;
            1: return 9999;
            2:
                case ($urandom_range(5))
                    0: return 1900;
                    1: return 2000;
                    2: return 2023;
                    3: return 2024;
                    4: return 2100;
                    default: return 2400;
                endcase
            default: return $urandom_range(9999, 1);
        endcase
    endfunction

    // Mostly legal calendar times near month edges, some raw bit noise
    function automatic cal_item_t random_item();
        int d;
        if ($urandom_range(99) < 82)
        begin
            if ($urandom_range(1) == 0)
                d = $urandom_range(31, 1);
            else
                case ($urandom_range(6))
                    0: d = 1;
                    1: d = 2;
                    2: d = 27;
                    3: d = 28;
                    4: d = 29;
                    5: d = 30;
                    default: d = 31;
                endcase
            return mk(pick_year(), $urandom_range(12, 1), d,
                      $urandom_range(23), $urandom_range(59), $urandom_range(59999),
                      ($urandom_range(1) == 0) ? int'($urandom_range(6)) - 3
                                               : int'($urandom_range(56)) - 28,
                      int'($urandom_range(96)) - 48,
                      int'($urandom_range(240)) - 120,
                      int'($urandom_range(240000)) - 120000);
        end
        return mk($urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Offer one beat after a random gap and hold it until taken
    task automatic send_item(cal_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        base_year   = it.base_year;
        base_month  = it.base_month;
        base_day    = it.base_day;
        base_hour   = it.base_hour;
        base_minute = it.base_minute;
        base_millis = it.base_millis;
        add_day     = it.add_day;
        add_hour    = it.add_hour;
        add_minute  = it.add_minute;
        add_millis  = it.add_millis;
        in_valid    = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering until every expected result has been taken
    task automatic drain();
        in_valid = 1'b0;
        while (sb.expected_times.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_random(int count, int send_pct, int recv_pct, bit with_pressure);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            if (with_pressure && i == 100)
                hold_left = 300;
            if (with_pressure && i == 250)
                drain();
            send_item(random_item());
        end
        drain();
    endtask

    initial
    begin
        cal_item_t directed[$];

        in_valid    = 1'b0;
        base_year   = '0;
        base_month  = '0;
        base_day    = '0;
        base_hour   = '0;
        base_minute = '0;
        base_millis = '0;
        add_day     = '0;
        add_hour    = '0;
        add_minute  = '0;
        add_millis  = '0;
        rst_n       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Field extremes and month-edge cases
        directed.push_back(mk(1, 1, 1, 0, 0, 0, -28, -48, -120, -120000));
        directed.push_back(mk(9999, 12, 31, 23, 59, 59999, 28, 48, 120, 120000));
        directed.push_back(mk(2023, 1, 1, 0, 0, 0, 0, 0, 0, -1));
        directed.push_back(mk(2023, 12, 31, 23, 59, 59999, 0, 0, 0, 1));
        directed.push_back(mk(2000, 2, 28, 12, 0, 0, 1, 0, 0, 0));
        directed.push_back(mk(2000, 2, 29, 12, 0, 0, 1, 0, 0, 0));
        directed.push_back(mk(1900, 2, 28, 12, 0, 0, 1, 0, 0, 0));
        directed.push_back(mk(2024, 3, 1, 0, 0, 0, -1, 0, 0, 0));
        directed.push_back(mk(2023, 3, 1, 0, 0, 0, -1, 0, 0, 0));
        directed.push_back(mk(2023, 5, 1, 0, 0, 0, -1, 0, 0, 0));
        directed.push_back(mk(2023, 7, 1, 0, 0, 0, -1, 0, 0, 0));
        directed.push_back(mk(2023, 10, 3, 0, 0, 0, -5, 0, 0, 0));
        directed.push_back(mk(2023, 12, 1, 0, 0, 0, -1, 0, 0, 0));
        directed.push_back(mk(2023, 4, 30, 0, 0, 0, 1, 0, 0, 0));
        directed.push_back(mk(2023, 8, 31, 23, 0, 0, 0, 1, 0, 0));
        directed.push_back(mk(2023, 0, 1, 0, 0, 0, -5, 0, 0, 0));
        directed.push_back(mk(2023, 15, 31, 0, 0, 0, 20, 0, 0, 0));
        directed.push_back(mk(0, 1, 1, 0, 0, 0, -1, 0, 0, 0));
        directed.push_back(mk(16383, 12, 31, 0, 0, 0, 1, 0, 0, 0));
        directed.push_back(mk(2023, 6, 0, 31, 63, 65535, -32, -64, -128, -131072));
        directed.push_back(mk(2023, 9, 31, 31, 63, 65535, 31, 63, 127, 131071));
        directed.push_back(mk(2023, 3, 15, 0, 0, 0, -28, 0, 0, 0));
        directed.push_back(mk(2023, 11, 30, 23, 59, 59999, 28, 48, 120, 120000));
        foreach (directed[k])
            send_item(directed[k]);
        drain();

        run_random(375, 7, 58, 1'b1);
        run_random(375, 58, 7, 1'b0);
        run_random(375, 0, 0, 1'b0);
        repeat (10) @(negedge clk);

        if (sb.mismatches == 0 && sb.expected_times.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
